// ===== design/vt4_pkg.sv =====
// Shared types and constants for the 4x4 vertex transform core.
`default_nettype none
package vt4_pkg;

  localparam int ELEM_W        = 32;
  localparam int VEC_LEN       = 4;
  localparam int ELEM_COUNT    = VEC_LEN * VEC_LEN;
  localparam int PAIR_COUNT    = ELEM_COUNT / 2;
  localparam int PAIR_IDX_W    = $clog2(PAIR_COUNT);
  localparam int CFG_DATA_W    = 2 * ELEM_W;
  localparam int CFG_BYTE_W    = $clog2(CFG_DATA_W / 8);
  localparam int CFG_ADDR_W    = PAIR_IDX_W + CFG_BYTE_W;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int PAIR_SUM_W    = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_word_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] vec_x;
    logic signed [ELEM_W-1:0] vec_y;
    logic signed [ELEM_W-1:0] vec_z;
    logic signed [ELEM_W-1:0] vec_w;
  } vec_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_x;
    logic signed [ELEM_W-1:0] out_y;
    logic signed [ELEM_W-1:0] out_z;
    logic signed [ELEM_W-1:0] out_w;
    logic                     overflow;
  } res_item_t;

endpackage
`default_nettype wire

// ===== design/vt4_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none
interface vt4_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/vt4_regfile.sv =====
// APB-style register file holding the sixteen matrix elements.
`default_nettype none
module vt4_regfile
  import vt4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire cfg_word_t             pwdata,
  output cfg_word_t                  prdata,
  output logic                       pready,
  output elem_t                      mat_elem [ELEM_COUNT]
);

  localparam cfg_word_t ONE_LO = cfg_word_t'(1) << FRAC_BITS;
  localparam cfg_word_t ONE_HI = ONE_LO << ELEM_W;

  cfg_word_t             pair_r [PAIR_COUNT];
  logic [PAIR_IDX_W-1:0] pair_idx;
  logic                  wr_en;

  assign pair_idx = paddr[CFG_ADDR_W-1:CFG_BYTE_W];
  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready;
  assign prdata   = pair_r[pair_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAIR_COUNT; k++) begin
        pair_r[k] <= (((2 * k) % (VEC_LEN + 1) == 0) ? ONE_LO : '0) |
                     (((2 * k + 1) % (VEC_LEN + 1) == 0) ? ONE_HI : '0);
      end
    end else if (wr_en) begin
      pair_r[pair_idx] <= pwdata;
    end
  end

  always_comb begin
    for (int e = 0; e < ELEM_COUNT; e++) begin
      if (e % 2 == 1) begin
        mat_elem[e] = pair_r[e / 2][CFG_DATA_W-1:ELEM_W];
      end else begin
        mat_elem[e] = pair_r[e / 2][ELEM_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/vt4_row_lane.sv =====
// Four-stage dot-product lane for one output component, with rounding and saturation.
`default_nettype none
module vt4_row_lane
  import vt4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire elem_t coef [VEC_LEN],
  input  wire elem_t vec  [VEC_LEN],
  output elem_t      res,
  output logic       sat
);

  localparam logic signed [SUM_W-1:0] ROUND_C =
    (SUM_W)'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0]     prod_r [VEC_LEN];
  logic signed [PROD_W-1:0]     prod_nxt [VEC_LEN];
  logic signed [PAIR_SUM_W-1:0] psum_r [VEC_LEN/2];
  logic signed [PAIR_SUM_W-1:0] psum_nxt [VEC_LEN/2];
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [SUM_W-1:0]      sum_nxt;
  logic signed [SUM_W-1:0]      shifted;
  logic                         too_big;
  logic                         too_small;
  elem_t                        res_r;
  elem_t                        res_nxt;
  logic                         sat_r;
  logic                         sat_nxt;

  always_comb begin
    for (int c = 0; c < VEC_LEN; c++) begin
      prod_nxt[c] = PROD_W'(coef[c]) * PROD_W'(vec[c]);
    end
    for (int p = 0; p < VEC_LEN / 2; p++) begin
      psum_nxt[p] = PAIR_SUM_W'(prod_r[2*p]) + PAIR_SUM_W'(prod_r[2*p+1]);
    end
    sum_nxt = SUM_W'(psum_r[0]) + SUM_W'(psum_r[1]) + ROUND_C;
  end

  always_comb begin
    shifted   = sum_r >>> FRAC_BITS;
    too_big   = !shifted[SUM_W-1] && (shifted[SUM_W-2:ELEM_W-1] != '0);
    too_small = shifted[SUM_W-1] && (shifted[SUM_W-2:ELEM_W-1] != '1);
    sat_nxt   = too_big | too_small;
    if (too_big) begin
      res_nxt = {1'b0, {(ELEM_W-1){1'b1}}};
    end else if (too_small) begin
      res_nxt = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res_nxt = shifted[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      psum_r <= psum_nxt;
      sum_r  <= sum_nxt;
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

// ===== design/vertex_transform_4x4_core.sv =====
// Top level of the 4x4 homogeneous vertex transform core.
// Throughput: one vector per cycle; the pipeline stages are products, pair sums,
// final sum with rounding, and shift with saturation into the output register.
// A stall on the result side freezes all four stages together.
// Reset clears the stage valid bits and loads the identity matrix.
`default_nettype none
module vertex_transform_4x4_core
  import vt4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vt4_stream_if.sink                 in_stream,
  vt4_stream_if.source               out_stream,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire cfg_word_t             pwdata,
  output cfg_word_t                  prdata,
  output logic                       pready
);

  localparam int STAGES = 4;

  elem_t              mat_elem [ELEM_COUNT];
  elem_t              vec [VEC_LEN];
  elem_t              coef_row [VEC_LEN][VEC_LEN];
  elem_t              lane_res [VEC_LEN];
  logic [VEC_LEN-1:0] lane_sat;
  logic [STAGES-1:0]  vld_r;
  logic [STAGES-1:0]  vld_nxt;
  logic               adv;

  vt4_regfile #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .mat_elem (mat_elem)
  );

  assign adv             = !vld_r[STAGES-1] || out_stream.ready;
  assign in_stream.ready = adv;
  assign vld_nxt         = {vld_r[STAGES-2:0], in_stream.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign vec[0] = in_stream.payload.vec_x;
  assign vec[1] = in_stream.payload.vec_y;
  assign vec[2] = in_stream.payload.vec_z;
  assign vec[3] = in_stream.payload.vec_w;

  always_comb begin
    for (int r = 0; r < VEC_LEN; r++) begin
      for (int c = 0; c < VEC_LEN; c++) begin
        coef_row[r][c] = mat_elem[VEC_LEN*c + r];
      end
    end
  end

  for (genvar r = 0; r < VEC_LEN; r++) begin : g_lane
    vt4_row_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (adv),
      .coef (coef_row[r]),
      .vec  (vec),
      .res  (lane_res[r]),
      .sat  (lane_sat[r])
    );
  end

  assign out_stream.valid            = vld_r[STAGES-1];
  assign out_stream.payload.out_x    = lane_res[0];
  assign out_stream.payload.out_y    = lane_res[1];
  assign out_stream.payload.out_z    = lane_res[2];
  assign out_stream.payload.out_w    = lane_res[3];
  assign out_stream.payload.overflow = |lane_sat;

endmodule
`default_nettype wire
